// ===== hdl/tva_pkg.sv =====
// shared types, constants and the arctangent table for the vertex angle block
package tva_pkg;

  localparam int unsigned CORDIC_LAST = 32;
  localparam int unsigned Z_BITS      = 36;
  localparam int unsigned ANGLE_BITS  = 16;
  localparam logic signed [Z_BITS-1:0] PI32 = 36'sd13493037704;

  typedef struct packed {
    logic compute;  // interior point, angle to be worked out
    logic fin;      // track ends here, a final not-defined result follows
  } job_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_NORM,
    ST_CORDIC,
    ST_ROUND,
    ST_OUT
  } back_state_e;

  // arctan(2^-i) in units of 2^-32 rad
  function automatic logic [31:0] atan_entry(input logic [5:0] i);
    logic [31:0] r;
    case (i)
      6'd0:    r = 32'd3373259426;
      6'd1:    r = 32'd1991351318;
      6'd2:    r = 32'd1052175346;
      6'd3:    r = 32'd534100635;
      6'd4:    r = 32'd268086748;
      6'd5:    r = 32'd134174063;
      6'd6:    r = 32'd67103403;
      6'd7:    r = 32'd33553749;
      6'd8:    r = 32'd16777131;
      6'd9:    r = 32'd8388597;
      6'd10:   r = 32'd4194303;
      default: r = 32'd1 << (6'd32 - i);
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/trajectory_vertex_angle.sv =====
// Vertex angle along a streamed polyline.
// Input channel (in_valid_i / in_stall_o) takes one point per transaction with
// an end-of-track mark. Output channel (out_valid_o / out_stall_i) gives one
// result per point in point order: angle in 2^-ANGLE_FRAC_BITS rad with a
// defined flag, a track_final flag and run_last on the last result of the
// transaction that caused it. An interior point's result leaves when the
// following point arrives; the first and last points of a track give
// not-defined results.
// The front end stores the two previous points and pushes jobs into a
// two-entry queue; it stalls only when the queue is full.
// The back end takes the job, accumulates the dot and cross products on one
// multiplier, runs a normalize loop, 33 cordic steps, a rounding step and an
// output state that holds while stalled. A zero-length segment result goes to
// output from the first multiply step; endpoint results go there from idle.
// A result waits in the output register while out_stall_i is high; the queue
// keeps taking points until it is full. Reset empties queue and stored points.
module trajectory_vertex_angle import tva_pkg::*; #(
  parameter int unsigned COORD_BITS      = 16,
  parameter int unsigned ANGLE_FRAC_BITS = 14
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_BITS-1:0] x_coord_i,
  input  logic [COORD_BITS-1:0] y_coord_i,
  input  logic                  end_of_track_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ANGLE_BITS-1:0] angle_o,
  output logic                  angle_defined_o,
  output logic                  track_final_o,
  output logic                  run_last_o
);

  localparam int unsigned QW = $bits(job_ctl_t) + 6 * COORD_BITS;

  logic                  push, pop, q_full, q_empty;
  job_ctl_t              f_ctl, b_ctl;
  logic [COORD_BITS-1:0] fpx, fpy, fmx, fmy, fnx, fny;
  logic [COORD_BITS-1:0] bpx, bpy, bmx, bmy, bnx, bny;
  logic [QW-1:0]         q_in, q_out;

  tva_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .x_coord_i, .y_coord_i,
    .end_of_track_i, .q_full_i(q_full), .push_o(push), .ctl_o(f_ctl),
    .px_o(fpx), .py_o(fpy), .mx_o(fmx), .my_o(fmy), .nx_o(fnx), .ny_o(fny)
  );

  assign q_in = {f_ctl, fpx, fpy, fmx, fmy, fnx, fny};
  assign {b_ctl, bpx, bpy, bmx, bmy, bnx, bny} = q_out;

  tva_queue #(.WIDTH(QW)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(q_in), .pop_i(pop),
    .data_o(q_out), .full_o(q_full), .empty_o(q_empty)
  );

  tva_back #(.COORD_BITS(COORD_BITS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .ctl_i(b_ctl),
    .px_i(bpx), .py_i(bpy), .mx_i(bmx), .my_i(bmy), .nx_i(bnx), .ny_i(bny),
    .pop_o(pop), .out_valid_o, .out_stall_i, .angle_o, .angle_defined_o,
    .track_final_o, .run_last_o
  );

  a_queue_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_full && q_empty)) else $error("queue full and empty at once");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty) else $error("pop from empty queue");

  a_end_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && end_of_track_i) |-> push)
    else $error("end of track produced no job");

  a_undef_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !angle_defined_o) |-> (angle_o == '0))
    else $error("not-defined result with nonzero angle");

endmodule

// ===== hdl/tva_front.sv =====
// front end: accepts points, keeps the two previous ones and issues jobs
module tva_front import tva_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_BITS-1:0] x_coord_i,
  input  logic [COORD_BITS-1:0] y_coord_i,
  input  logic                  end_of_track_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output job_ctl_t              ctl_o,
  output logic [COORD_BITS-1:0] px_o,
  output logic [COORD_BITS-1:0] py_o,
  output logic [COORD_BITS-1:0] mx_o,
  output logic [COORD_BITS-1:0] my_o,
  output logic [COORD_BITS-1:0] nx_o,
  output logic [COORD_BITS-1:0] ny_o
);

  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_TWO  = 2'd2;

  logic [1:0]            seen_q, seen_d;
  logic [COORD_BITS-1:0] x0_q, y0_q, x1_q, y1_q;
  logic                  acc;

  assign in_stall_o = q_full_i;
  assign acc        = in_valid_i && !q_full_i;
  assign push_o     = acc && !(seen_q == SEEN_ONE && !end_of_track_i);
  assign ctl_o.compute = (seen_q == SEEN_TWO);
  assign ctl_o.fin     = end_of_track_i;
  assign px_o = x1_q;
  assign py_o = y1_q;
  assign mx_o = x0_q;
  assign my_o = y0_q;
  assign nx_o = x_coord_i;
  assign ny_o = y_coord_i;

  always_comb begin
    seen_d = seen_q;
    if (acc) begin
      if (end_of_track_i) begin
        seen_d = SEEN_NONE;
      end else if (seen_q == SEEN_NONE) begin
        seen_d = SEEN_ONE;
      end else begin
        seen_d = SEEN_TWO;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= SEEN_NONE;
      x0_q   <= '0;
      y0_q   <= '0;
      x1_q   <= '0;
      y1_q   <= '0;
    end else if (acc) begin
      seen_q <= seen_d;
      if (end_of_track_i) begin
        x0_q <= '0;
        y0_q <= '0;
        x1_q <= '0;
        y1_q <= '0;
      end else begin
        x1_q <= x0_q;
        y1_q <= y0_q;
        x0_q <= x_coord_i;
        y0_q <= y_coord_i;
      end
    end
  end

endmodule

// ===== hdl/tva_queue.sv =====
// two-entry job queue between front and back
module tva_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= !wp_q;
      end
      if (pop_i) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ===== hdl/tva_back.sv =====
// back end: dot and cross products, normalize, cordic vectoring, rounding, output
module tva_back import tva_pkg::*; #(
  parameter int unsigned COORD_BITS      = 16,
  parameter int unsigned ANGLE_FRAC_BITS = 14
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  input  job_ctl_t              ctl_i,
  input  logic [COORD_BITS-1:0] px_i,
  input  logic [COORD_BITS-1:0] py_i,
  input  logic [COORD_BITS-1:0] mx_i,
  input  logic [COORD_BITS-1:0] my_i,
  input  logic [COORD_BITS-1:0] nx_i,
  input  logic [COORD_BITS-1:0] ny_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ANGLE_BITS-1:0] angle_o,
  output logic                  angle_defined_o,
  output logic                  track_final_o,
  output logic                  run_last_o
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned AW = PW + 1;
  localparam logic [63:0] TOP_HI = 64'd1 << 60;
  localparam logic [63:0] TOP_LO = 64'd1 << 59;
  localparam logic [63:0] COARSE = 64'd1 << 52;
  localparam logic [34:0] HALF   = 35'd1 << (31 - ANGLE_FRAC_BITS);

  back_state_e state_q, state_d;

  logic signed [DW-1:0] ax_q, ay_q, bx_q, by_q;
  logic [1:0]           k_q;
  logic signed [AW-1:0] dot_q, crs_q, dot_nx, crs_nx;
  logic signed [63:0]   xv_q, yv_q, dx, dy, dot64, crs64;
  logic signed [Z_BITS-1:0] z_q, zr, zstep;
  logic [5:0]           i_q;
  logic                 obtuse_q, fin_q, tail_q;
  logic signed [DW-1:0] opa, opb;
  logic signed [PW-1:0] prod;
  logic [63:0]          big;
  logic [34:0]          zc, zsum;
  logic [ANGLE_BITS-1:0] ang;
  logic                 zero_seg, out_take;

  // controls
  logic ld_job, ld_undef, ld_angle, ld_tail;

  function automatic logic signed [DW-1:0] diff(input logic [COORD_BITS-1:0] a,
                                                input logic [COORD_BITS-1:0] b);
    logic signed [DW-1:0] ea, eb;
    ea = DW'($signed(a));
    eb = DW'($signed(b));
    return ea - eb;
  endfunction

  // one shared multiplier: ax*bx, ay*by, ax*by, ay*bx
  assign opa  = k_q[0] ? ay_q : ax_q;
  assign opb  = (k_q[0] ^ k_q[1]) ? by_q : bx_q;
  assign prod = PW'(opa) * PW'(opb);

  always_comb begin
    dot_nx = dot_q;
    crs_nx = crs_q;
    case (k_q)
      2'd0, 2'd1: dot_nx = dot_q + AW'(prod);
      2'd2:       crs_nx = crs_q + AW'(prod);
      default:    crs_nx = crs_q - AW'(prod);
    endcase
  end

  assign dot64 = 64'(dot_nx);
  assign crs64 = 64'(crs_nx);
  assign zero_seg = (ax_q == '0 && ay_q == '0) || (bx_q == '0 && by_q == '0);
  assign big = ($unsigned(xv_q) > $unsigned(yv_q)) ? xv_q : yv_q;

  assign dx    = yv_q >>> i_q;
  assign dy    = xv_q >>> i_q;
  assign zstep = $signed({4'd0, atan_entry(i_q)});

  // fold for obtuse angles, clamp to [0, pi], round
  always_comb begin
    zr = obtuse_q ? (PI32 - z_q) : z_q;
    if (zr[Z_BITS-1]) begin
      zc = '0;
    end else if (zr > PI32) begin
      zc = 35'(PI32);
    end else begin
      zc = 35'(zr);
    end
    zsum = zc + HALF;
    ang  = ANGLE_BITS'(zsum >> (32 - ANGLE_FRAC_BITS));
  end

  assign out_take = (state_q == ST_OUT) && !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          state_d = ctl_i.compute ? ST_MUL : ST_OUT;
        end
      end
      ST_MUL: begin
        if (k_q == 2'd0 && zero_seg) begin
          state_d = ST_OUT;
        end else if (k_q == 2'd3) begin
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        if (big < TOP_HI && big >= TOP_LO) begin
          state_d = ST_CORDIC;
        end
      end
      ST_CORDIC: begin
        if (i_q == 6'(CORDIC_LAST)) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: state_d = ST_OUT;
      ST_OUT: begin
        if (out_take && !tail_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ld_job   = (state_q == ST_IDLE) && !q_empty_i;
    ld_undef = (state_q == ST_MUL) && (k_q == 2'd0) && zero_seg;
    ld_angle = (state_q == ST_ROUND);
    ld_tail  = out_take && tail_q;
    pop_o    = ld_job;
  end

  assign out_valid_o = (state_q == ST_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tail_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ld_job) begin
        tail_q <= 1'b0;
      end else if (ld_undef || ld_angle) begin
        tail_q <= fin_q;
      end else if (ld_tail) begin
        tail_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_job) begin
      ax_q  <= diff(px_i, mx_i);
      ay_q  <= diff(py_i, my_i);
      bx_q  <= diff(nx_i, mx_i);
      by_q  <= diff(ny_i, my_i);
      fin_q <= ctl_i.fin;
      k_q   <= 2'd0;
      dot_q <= '0;
      crs_q <= '0;
      angle_o         <= '0;
      angle_defined_o <= 1'b0;
      track_final_o   <= ctl_i.fin;
      run_last_o      <= 1'b1;
    end
    if (state_q == ST_MUL) begin
      k_q   <= k_q + 2'd1;
      dot_q <= dot_nx;
      crs_q <= crs_nx;
      if (k_q == 2'd3) begin
        obtuse_q <= dot64[63];
        xv_q     <= dot64[63] ? -dot64 : dot64;
        yv_q     <= crs64[63] ? -crs64 : crs64;
      end
    end
    if (state_q == ST_NORM) begin
      i_q <= '0;
      z_q <= '0;
      if (big >= TOP_HI) begin
        xv_q <= xv_q >>> 1;
        yv_q <= yv_q >>> 1;
      end else if (big < COARSE) begin
        xv_q <= xv_q <<< 8;
        yv_q <= yv_q <<< 8;
      end else if (big < TOP_LO) begin
        xv_q <= xv_q <<< 1;
        yv_q <= yv_q <<< 1;
      end
    end
    if (state_q == ST_CORDIC) begin
      i_q <= i_q + 6'd1;
      if (!yv_q[63]) begin
        xv_q <= xv_q + dx;
        yv_q <= yv_q - dy;
        z_q  <= z_q + zstep;
      end else begin
        xv_q <= xv_q - dx;
        yv_q <= yv_q + dy;
        z_q  <= z_q - zstep;
      end
    end
    if (ld_undef || ld_angle) begin
      angle_o         <= ld_angle ? ang : '0;
      angle_defined_o <= ld_angle;
      track_final_o   <= 1'b0;
      run_last_o      <= !fin_q;
    end
    if (ld_tail) begin
      angle_o         <= '0;
      angle_defined_o <= 1'b0;
      track_final_o   <= 1'b1;
      run_last_o      <= 1'b1;
    end
  end

endmodule

// ===== tb/sv/trajectory_vertex_angle_tb.sv =====
// self-checking testbench for the trajectory vertex angle block
module trajectory_vertex_angle_tb;
  import tva_pkg::*;

  typedef struct {
    logic [ANGLE_BITS-1:0] angle;
    logic                  defined;
    logic                  fin;
    logic                  last;
  } vertex_result_t;

  localparam longint PI_Q32 = 64'sd13493037704;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] x_coord_i = '0;
  logic [15:0] y_coord_i = '0;
  logic        end_of_track_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [ANGLE_BITS-1:0] angle_o;
  logic        angle_defined_o;
  logic        track_final_o;
  logic        run_last_o;

  trajectory_vertex_angle DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .x_coord_i, .y_coord_i,
    .end_of_track_i, .out_valid_o, .out_stall_i, .angle_o, .angle_defined_o,
    .track_final_o, .run_last_o
  );

  // predictor state: held points and count
  longint         held_x [2];
  longint         held_y [2];
  int unsigned    held_cnt;
  vertex_result_t pending_angles [$];
  int unsigned    mismatches;
  int unsigned    in_gap_max;
  int unsigned    out_gap_max;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic longint cordic_magnitude_free(longint ux_in, longint uy_in);
    longint xv, yv, z, dx, dy, big;
    xv = ux_in;
    yv = uy_in;
    z = 0;
    big = (xv > yv) ? xv : yv;
    while (big >= (64'sd1 <<< 60)) begin
      xv = xv >>> 1; yv = yv >>> 1; big = big >>> 1;
    end
    while (big < (64'sd1 <<< 59)) begin
      xv = xv <<< 1; yv = yv <<< 1; big = big <<< 1;
    end
    for (int i = 0; i <= 32; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv >= 0) begin
        xv += dx; yv -= dy; z += longint'(atan_entry(i[5:0]));
      end else begin
        xv -= dx; yv += dy; z -= longint'(atan_entry(i[5:0]));
      end
    end
    return z;
  endfunction

  // angle at the middle point; returns 0 when a segment has zero length
  function automatic bit vertex_angle_of(longint px, longint py, longint mx, longint my,
                                         longint nx, longint ny,
                                         output logic [ANGLE_BITS-1:0] ang);
    longint ax, ay, bx, by, dot, crs, z;
    ax = px - mx; ay = py - my; bx = nx - mx; by = ny - my;
    ang = '0;
    if ((ax == 0 && ay == 0) || (bx == 0 && by == 0)) return 1'b0;
    dot = ax * bx + ay * by;
    crs = ax * by - ay * bx;
    z = cordic_magnitude_free(dot < 0 ? -dot : dot, crs < 0 ? -crs : crs);
    if (dot < 0) z = PI_Q32 - z;
    if (z < 0) z = 0;
    if (z > PI_Q32) z = PI_Q32;
    z = (z + (64'sd1 <<< 17)) >>> 18;
    ang = z[ANGLE_BITS-1:0];
    return 1'b1;
  endfunction

  task automatic push_result(logic [ANGLE_BITS-1:0] a, logic d, logic f, logic l);
    vertex_result_t r;
    r.angle = a; r.defined = d; r.fin = f; r.last = l;
    pending_angles.push_back(r);
  endtask

  task automatic predict_point(logic [15:0] xr, logic [15:0] yr, logic eot);
    longint x, y;
    logic [ANGLE_BITS-1:0] a;
    bit d;
    x = longint'($signed(xr));
    y = longint'($signed(yr));
    if (held_cnt == 0) begin
      push_result('0, 1'b0, eot, 1'b1);
    end else if (held_cnt == 1) begin
      if (eot) push_result('0, 1'b0, 1'b1, 1'b1);
    end else begin
      d = vertex_angle_of(held_x[1], held_y[1], held_x[0], held_y[0], x, y, a);
      push_result(d ? a : '0, d, 1'b0, !eot);
      if (eot) push_result('0, 1'b0, 1'b1, 1'b1);
    end
    if (eot) begin
      held_x = '{0, 0}; held_y = '{0, 0}; held_cnt = 0;
    end else begin
      held_x[1] = held_x[0]; held_y[1] = held_y[0];
      held_x[0] = x; held_y[0] = y;
      held_cnt = (held_cnt >= 2) ? 2 : held_cnt + 1;
    end
  endtask

  task automatic send_point(logic [15:0] xr, logic [15:0] yr, logic eot);
    int unsigned gap;
    gap = $urandom_range(in_gap_max, 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    x_coord_i      <= xr;
    y_coord_i      <= yr;
    end_of_track_i <= eot;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_point(xr, yr, eot);
  endtask

  // receiver: compare each transaction, draw stall length per result
  initial begin
    int unsigned stall_left;
    vertex_result_t e;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (pending_angles.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result angle=%0d", angle_o);
        end else begin
          e = pending_angles.pop_front();
          if (angle_o !== e.angle || angle_defined_o !== e.defined ||
              track_final_o !== e.fin || run_last_o !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp ang=%0d def=%b fin=%b last=%b ",
                        "got ang=%0d def=%b fin=%b last=%b"},
                       e.angle, e.defined, e.fin, e.last,
                       angle_o, angle_defined_o, track_final_o, run_last_o);
          end
        end
        stall_left = $urandom_range(out_gap_max, 0);
      end
      out_stall_i <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  task automatic test_endpoints();
    in_gap_max = 0; out_gap_max = 0;
    send_point(16'd5, 16'd5, 1'b1);                  // single-point track
    send_point(16'd1, 16'd2, 1'b0);                  // two-point track
    send_point(16'd3, 16'd4, 1'b1);
    send_point(16'd0, 16'd0, 1'b0);                  // zero-length segments
    send_point(16'd0, 16'd0, 1'b0);
    send_point(16'd7, 16'd0, 1'b0);
    send_point(16'd7, 16'd0, 1'b1);
  endtask

  task automatic test_special_angles();
    in_gap_max = 10; out_gap_max = 10;
    send_point(16'd0, 16'd0, 1'b0);                  // straight line, right angle
    send_point(16'd10, 16'd0, 1'b0);
    send_point(16'd20, 16'd0, 1'b0);
    send_point(16'd20, 16'd10, 1'b0);
    send_point(16'd0, 16'd0, 1'b0);                  // acute, doubling back
    send_point(16'd10, 16'd0, 1'b1);
  endtask

  task automatic test_extremes();
    in_gap_max = 3; out_gap_max = 3;
    send_point(16'h8000, 16'h8000, 1'b0);
    send_point(16'h7fff, 16'h7fff, 1'b0);
    send_point(16'h8000, 16'h7fff, 1'b0);
    send_point(16'h7fff, 16'h8000, 1'b0);
    send_point(16'hffff, 16'h0000, 1'b0);
    send_point(16'h8000, 16'h8000, 1'b0);
    send_point(16'h7fff, 16'h8001, 1'b1);
  endtask

  task automatic test_random_tracks();
    int unsigned sent, len, span;
    logic [15:0] xr, yr;
    sent = 0;
    while (sent < 1730) begin
      len = $urandom_range(8, 1);
      span = $urandom_range(3, 0);
      in_gap_max  = ($urandom_range(3, 0) == 0) ? 0 : 10;
      out_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 10;
      for (int k = 0; k < len; k++) begin
        case (span)
          0:       begin xr = 16'($urandom_range(2, 0)); yr = 16'($urandom_range(2, 0)); end
          1:       begin xr = 16'($signed($urandom_range(200, 0)) - 100);
                         yr = 16'($signed($urandom_range(200, 0)) - 100); end
          default: begin xr = 16'($urandom); yr = 16'($urandom); end
        endcase
        send_point(xr, yr, k == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    held_x = '{0, 0}; held_y = '{0, 0}; held_cnt = 0;
    mismatches = 0; in_gap_max = 0; out_gap_max = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_endpoints();
    test_special_angles();
    test_extremes();
    test_random_tracks();
    in_valid_i <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
